[hw/rtl/u2g_pkg.sv]
// ----------------------------------------------------------------------------
// u2g_pkg
// Shared types and constants of the UTF-8 to GBK stream converter.
// ----------------------------------------------------------------------------
package u2g_pkg;

   localparam logic REQ_DATA  = 1'b0;
   localparam logic REQ_TABLE = 1'b1;

   localparam logic [7:0] ASCII_LIMIT = 8'h80;
   localparam logic [7:0] LEAD2_MIN   = 8'hC2;
   localparam logic [7:0] LEAD3_MIN   = 8'hE0;
   localparam logic [7:0] LEAD4_MIN   = 8'hF0;

   localparam logic [1:0]  SKIP_LEN  = 2'd3;
   localparam logic [23:0] COUNT_MAX = 24'hFFFFFF;

   localparam int Q_DEPTH = 4;
   localparam int QPW     = $clog2(Q_DEPTH);
   localparam int QCW     = $clog2(Q_DEPTH + 1);

   typedef struct packed {
      logic        req_type;
      logic [7:0]  in_byte;
      logic        last_byte;
      logic [15:0] table_index;
      logic [15:0] table_value;
   } req_item_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        is_end;
      logic [23:0] out_count;
   } rsp_item_type;

   typedef enum logic [1:0] {
      KIND_NONE   = 2'd0,
      KIND_BYTE   = 2'd1,
      KIND_LOOKUP = 2'd2
   } kind_type;

   // decoded item waiting for its table read
   typedef struct packed {
      kind_type   kind;
      logic [7:0] data;
      logic       oob;
      logic       last;
   } op_type;

   // queued work for the back end: nbytes data bytes, then a terminator if last
   typedef struct packed {
      logic [1:0] nbytes;
      logic [7:0] hi;
      logic [7:0] lo;
      logic       last;
   } entry_type;

endpackage

[hw/rtl/utf8_to_gbk_stream_converter.sv]
// ----------------------------------------------------------------------------
// utf8_to_gbk_stream_converter
// UTF-8 to GBK stream converter with a loadable code table.
// ----------------------------------------------------------------------------
// After reset the block holds req_stall high while it clears the code table,
// one entry per cycle. It then accepts one item per cycle, data byte or table
// write, as long as the four-entry work queue has room. A table write takes
// effect for any later lookup. A data byte reaches rsp through the table read,
// the work queue and the output register. The output stage gives one result
// item per cycle while rsp_stall is low, so a data byte that yields two or
// three items (a GBK pair, or a byte carrying last_byte) holds the input back
// once the queue fills; the sustained rate is one input item per cycle for
// ordinary text while rsp_stall stays low.
module utf8_to_gbk_stream_converter
   import u2g_pkg::*;
#(
   parameter int TABLE_DEPTH = 65536
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_item,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_item
);

   logic           push_valid;
   entry_type      push_entry;
   logic           pop;
   logic           head_valid;
   entry_type      head_entry;
   logic [QCW-1:0] q_level;

   u2g_front #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .q_level    (q_level),
      .push_valid (push_valid),
      .push_entry (push_entry)
   );

   u2g_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .level      (q_level)
   );

   u2g_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_item   (rsp_item)
   );

endmodule

[hw/rtl/u2g_ram.sv]
// ----------------------------------------------------------------------------
// u2g_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module u2g_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/u2g_front.sv]
// ----------------------------------------------------------------------------
// u2g_front
// Accepts items, decodes UTF-8, clears and writes the code table, reads it
// for completed code points and pushes the resulting work into the queue.
// ----------------------------------------------------------------------------
module u2g_front
   import u2g_pkg::*;
#(
   parameter int TABLE_DEPTH = 65536
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_item_type     req_item,
   input  logic [QCW-1:0]   q_level,
   output logic             push_valid,
   output entry_type        push_entry
);

   localparam int AW = $clog2(TABLE_DEPTH);

   logic          clear_busy_ff, clear_busy_in;
   logic [AW-1:0] clear_addr_ff, clear_addr_in;

   logic [1:0]  need_ff, need_in;
   logic [15:0] partial_ff, partial_in;
   logic [1:0]  skip_ff, skip_in;

   logic   s1_valid_ff, s1_valid_in;
   op_type s1_op_ff, s1_op_in;

   logic          accept;
   logic          data_acc;
   logic [QCW:0]  used;
   logic [15:0]   code;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [15:0]   wr_data;
   logic          rd_en;
   logic [15:0]   rd_data;
   logic [15:0]   gbk;
   logic [7:0]    b;

   assign used      = (QCW + 1)'(q_level) + (QCW + 1)'(s1_valid_ff);
   assign req_stall = clear_busy_ff || (used >= (QCW + 1)'(Q_DEPTH));
   assign accept    = req_valid && !req_stall;
   assign data_acc  = accept && (req_item.req_type == REQ_DATA);
   assign b         = req_item.in_byte;
   assign code      = {partial_ff[9:0], b[5:0]};

   always_comb begin
      need_in    = need_ff;
      partial_in = partial_ff;
      skip_in    = skip_ff;
      s1_op_in   = '{kind: KIND_NONE, data: b, oob: (32'(code) >= TABLE_DEPTH),
                     last: req_item.last_byte};
      rd_en      = 1'b0;
      if (data_acc) begin
         if (skip_ff != 2'd0) begin
            skip_in = skip_ff - 2'd1;
         end else if (need_ff != 2'd0) begin
            partial_in = code;
            need_in    = need_ff - 2'd1;
            if (need_ff == 2'd1) begin
               s1_op_in.kind = KIND_LOOKUP;
               rd_en         = 1'b1;
            end
         end else if (b < ASCII_LIMIT) begin
            s1_op_in.kind = KIND_BYTE;
         end else if (b < LEAD2_MIN) begin
            partial_in = partial_ff;
         end else if (b < LEAD3_MIN) begin
            partial_in = {11'd0, b[4:0]};
            need_in    = 2'd1;
         end else if (b < LEAD4_MIN) begin
            partial_in = {12'd0, b[3:0]};
            need_in    = 2'd2;
         end else begin
            skip_in = SKIP_LEN;
         end
         if (req_item.last_byte) begin
            need_in    = 2'd0;
            partial_in = 16'd0;
            skip_in    = 2'd0;
         end
      end
   end

   // table clearing after reset, then writes from the stream
   always_comb begin
      clear_busy_in = clear_busy_ff;
      clear_addr_in = clear_addr_ff;
      if (clear_busy_ff) begin
         wr_en         = 1'b1;
         wr_addr       = clear_addr_ff;
         wr_data       = 16'd0;
         clear_addr_in = clear_addr_ff + AW'(1);
         if (clear_addr_ff == AW'(TABLE_DEPTH - 1)) begin
            clear_busy_in = 1'b0;
         end
      end else begin
         wr_en   = accept && (req_item.req_type == REQ_TABLE)
                   && (32'(req_item.table_index) < TABLE_DEPTH);
         wr_addr = req_item.table_index[AW-1:0];
         wr_data = req_item.table_value;
      end
   end

   assign s1_valid_in = data_acc;

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_busy_ff <= 1'b1;
         clear_addr_ff <= '0;
         need_ff       <= 2'd0;
         partial_ff    <= 16'd0;
         skip_ff       <= 2'd0;
         s1_valid_ff   <= 1'b0;
      end else begin
         clear_busy_ff <= clear_busy_in;
         clear_addr_ff <= clear_addr_in;
         need_ff       <= need_in;
         partial_ff    <= partial_in;
         skip_ff       <= skip_in;
         s1_valid_ff   <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_op_ff <= s1_op_in;
   end

   u2g_ram #(
      .WIDTH (16),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (code[AW-1:0]),
      .rd_data (rd_data)
   );

   assign gbk = s1_op_ff.oob ? 16'd0 : rd_data;

   always_comb begin
      push_entry.hi   = s1_op_ff.data;
      push_entry.lo   = 8'd0;
      push_entry.last = s1_op_ff.last;
      case (s1_op_ff.kind)
         KIND_BYTE: begin
            push_entry.nbytes = 2'd1;
         end
         KIND_LOOKUP: begin
            push_entry.hi     = gbk[15:8];
            push_entry.lo     = gbk[7:0];
            push_entry.nbytes = (gbk != 16'd0) ? 2'd2 : 2'd0;
         end
         default: begin
            push_entry.nbytes = 2'd0;
         end
      endcase
   end

   assign push_valid = s1_valid_ff && ((push_entry.nbytes != 2'd0) || push_entry.last);

`ifndef NO_ASSERTIONS
   a_no_accept_clearing: assert property (@(posedge clock) disable iff (reset)
      clear_busy_ff |-> !accept)
      else $error("item accepted during table clear");

   a_lookup_one_cycle: assert property (@(posedge clock) disable iff (reset)
      rd_en |=> s1_valid_ff && (s1_op_ff.kind == KIND_LOOKUP))
      else $error("table read not followed by lookup stage");
`endif

endmodule

[hw/rtl/u2g_queue.sv]
// ----------------------------------------------------------------------------
// u2g_queue
// Small FIFO of work entries between the decoder and the output stage.
// ----------------------------------------------------------------------------
module u2g_queue
   import u2g_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push_valid,
   input  entry_type      push_entry,
   input  logic           pop,
   output logic           head_valid,
   output entry_type      head_entry,
   output logic [QCW-1:0] level
);

   entry_type      q_ff [Q_DEPTH];
   logic [QPW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCW-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push_valid ? wr_ptr_ff + QPW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPW'(1) : rd_ptr_ff;
      count_in  = count_ff + QCW'(push_valid) - QCW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         q_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head_valid = (count_ff != '0);
   assign head_entry = q_ff[rd_ptr_ff];
   assign level      = count_ff;

`ifndef NO_ASSERTIONS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> (count_ff < QCW'(Q_DEPTH)) || pop)
      else $error("queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("queue underflow");
`endif

endmodule

[hw/rtl/u2g_back.sv]
// ----------------------------------------------------------------------------
// u2g_back
// Expands queued work into result items, one per cycle while rsp_stall is low,
// keeps the per-string byte count and holds the output register.
// ----------------------------------------------------------------------------
module u2g_back
   import u2g_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         head_valid,
   input  entry_type    head_entry,
   output logic         pop,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_item
);

   logic [1:0]   phase_ff, phase_in;
   logic [23:0]  count_ff, count_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff, rsp_item_in;

   logic       load;
   logic       emit;
   logic [1:0] n_items;
   logic       is_byte;

   assign load    = !rsp_valid_ff || !rsp_stall;
   assign emit    = head_valid && load;
   assign n_items = head_entry.nbytes + 2'(head_entry.last);
   assign is_byte = (phase_ff < head_entry.nbytes);
   assign pop     = emit && (phase_ff == n_items - 2'd1);

   always_comb begin
      phase_in     = phase_ff;
      count_in     = count_ff;
      rsp_valid_in = load ? emit : rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      if (emit) begin
         phase_in = pop ? 2'd0 : phase_ff + 2'd1;
         if (is_byte) begin
            rsp_item_in.out_byte  = (phase_ff == 2'd0) ? head_entry.hi : head_entry.lo;
            rsp_item_in.is_end    = 1'b0;
            rsp_item_in.out_count = 24'd0;
            if (count_ff != COUNT_MAX) begin
               count_in = count_ff + 24'd1;
            end
         end else begin
            rsp_item_in.out_byte  = 8'd0;
            rsp_item_in.is_end    = 1'b1;
            rsp_item_in.out_count = count_ff;
            count_in              = 24'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= 2'd0;
         count_ff     <= 24'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

`ifndef NO_ASSERTIONS
   a_count_clears_on_end: assert property (@(posedge clock) disable iff (reset)
      (emit && !is_byte) |=> (count_ff == 24'd0) && rsp_item_ff.is_end)
      else $error("count not cleared after terminator");
`endif

endmodule
